### src/tfcl_pkg.sv
// shared types and constants for the transfer function color lookup
package tfcl_pkg;

	// default table depth
	localparam int MAX_POINTS_DEF = 16;

	// fixed field widths
	localparam int POS_W      = 16;
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 4 * CHAN_W;
	localparam int IDX_W      = 4;
	localparam int CNT_REG_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int ENTRY_W    = POS_W + COLOR_W;
	localparam int DIFF_W     = POS_W + 1;
	localparam int REM_W      = 2 * CHAN_W + DIFF_W + 1;

	// input function codes
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// interpolation mode codes
	localparam logic MODE_LINEAR  = 1'b0;
	localparam logic MODE_NEAREST = 1'b1;

	// register reset values
	localparam logic [CNT_REG_W-1:0] POINT_COUNT_RST = 5'd2;
	localparam logic INTERP_MODE_RST   = MODE_LINEAR;
	localparam logic CLAMP_OUTSIDE_RST = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POINT_COUNT   = 2'd0,
		CFG_INTERP_MODE   = 2'd1,
		CFG_CLAMP_OUTSIDE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} bk_state_t;

	typedef struct packed {
		logic                    func;
		logic [IDX_W-1:0]        point_index;
		logic signed [POS_W-1:0] point_position;
		logic [CHAN_W-1:0]       in_red;
		logic [CHAN_W-1:0]       in_green;
		logic [CHAN_W-1:0]       in_blue;
		logic [CHAN_W-1:0]       in_alpha;
		logic signed [POS_W-1:0] sample;
	} in_beat_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
	} out_beat_t;

	// queued command, color packed red in the low byte
	typedef struct packed {
		cmd_kind_t               kind;
		logic [IDX_W-1:0]        index;
		logic signed [POS_W-1:0] position;
		logic [COLOR_W-1:0]      color;
		logic signed [POS_W-1:0] sample;
	} cmd_t;

	typedef struct packed {
		logic [CNT_REG_W-1:0] point_count;
		logic                 interp_mode;
		logic                 clamp_outside;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic load;
	} bk_stat_t;

endpackage

### src/tfcl_stream_if.sv
// valid/ready stream channel with a typed payload
interface tfcl_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### src/tfcl_ram.sv
// generic single write port ram with registered read
module tfcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/tfcl_front.sv
// front end: accepts beats, classifies them and queues commands
module tfcl_front #(
	parameter int MAX_POINTS = tfcl_pkg::MAX_POINTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	tfcl_stream_if.sink    item,
	output logic           q_valid,
	output tfcl_pkg::cmd_t q_head,
	input  logic           q_pop
);

	tfcl_pkg::cmd_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           accept;
	logic           keep;
	logic           pop;
	tfcl_pkg::cmd_t cmd_in;

	assign item.ready = (fill_q != 2'd2);
	assign accept     = item.valid && item.ready;

	// writes to slots past the table are dropped here
	assign keep = accept && ((item.payload.func == tfcl_pkg::FUNC_LOOKUP) ||
		(32'(item.payload.point_index) < MAX_POINTS));

	always_comb begin
		cmd_in.kind     = (item.payload.func == tfcl_pkg::FUNC_LOOKUP) ?
			tfcl_pkg::CMD_LOOKUP : tfcl_pkg::CMD_WRITE;
		cmd_in.index    = item.payload.point_index;
		cmd_in.position = item.payload.point_position;
		cmd_in.color    = {item.payload.in_alpha, item.payload.in_blue,
			item.payload.in_green, item.payload.in_red};
		cmd_in.sample   = item.payload.sample;
	end

	assign q_valid = (fill_q != 2'd0);
	assign q_head  = fifo_q[rd_ptr_q];
	assign pop     = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (keep) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(keep) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

### src/tfcl_back.sv
// back end: point table, neighbor scan, blend divider and result register
module tfcl_back #(
	parameter int MAX_POINTS = tfcl_pkg::MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tfcl_pkg::cfg_t     cfg,
	input  logic               q_valid,
	input  tfcl_pkg::cmd_t     q_head,
	output logic               q_pop,
	tfcl_stream_if.source      result,
	output tfcl_pkg::bk_stat_t stat
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int PW = tfcl_pkg::POS_W;
	localparam int KW = tfcl_pkg::CHAN_W;
	localparam int DW = tfcl_pkg::DIFF_W;
	localparam int RW = tfcl_pkg::REM_W;

	tfcl_pkg::bk_state_t state_q, state_d;

	logic                              ram_we;
	logic [tfcl_pkg::ENTRY_W-1:0]      ram_rdata;
	logic signed [PW-1:0]              rd_pos;
	logic [tfcl_pkg::COLOR_W-1:0]      rd_color;
	logic [CW-1:0]                     cnt;
	logic [CW-1:0]                     idx_q;
	logic signed [PW-1:0]              s_q, p_q, n_q;
	logic [tfcl_pkg::COLOR_W-1:0]      cp_q, cn_q, acc_q;
	logic                              have_lo_q, have_hi_q, blend_q;
	logic [DW-1:0]                     dp_q, dn_q, den_q;
	logic [DW-1:0]                     dp_w, dn_w, den_w;
	logic [RW-1:0]                     rem_q [4];
	logic [RW-1:0]                     mul_sum [4];
	logic [RW-1:0]                     trial;
	logic [KW-1:0]                     quot_q [4];
	logic [2:0]                        bit_q;
	logic [tfcl_pkg::COLOR_W-1:0]      pick;
	logic                              hit;
	logic                              out_load;
	logic                              out_valid_q;
	tfcl_pkg::out_beat_t               res_q;
	logic [tfcl_pkg::COLOR_W-1:0]      res_word;

	tfcl_ram #(
		.WIDTH (tfcl_pkg::ENTRY_W),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(q_head.index)),
		.wdata ({q_head.color, q_head.position}),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_pos   = ram_rdata[PW-1:0];
	assign rd_color = ram_rdata[tfcl_pkg::ENTRY_W-1:PW];

	// points in use, capped at the table depth
	assign cnt = (32'(cfg.point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(cfg.point_count);

	assign hit = (s_q < rd_pos);

	// distances to the neighbors, never negative once both are found
	assign dp_w  = {s_q[PW-1], s_q} - {p_q[PW-1], p_q};
	assign dn_w  = {n_q[PW-1], n_q} - {s_q[PW-1], s_q};
	assign den_w = {n_q[PW-1], n_q} - {p_q[PW-1], p_q};

	// color for every case but the linear blend
	always_comb begin
		if (!have_lo_q) begin
			pick = (cfg.clamp_outside || !have_hi_q) ? '0 : cn_q;
		end else if (!have_hi_q) begin
			pick = (cfg.clamp_outside && (s_q != p_q)) ? '0 : cp_q;
		end else begin
			pick = (dp_w < dn_w) ? cp_q : cn_q;
		end
	end

	// blend numerator per channel, plus half the span for rounding
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mul_sum[k] = RW'(cp_q[KW*k +: KW]) * RW'(dn_q) +
				RW'(cn_q[KW*k +: KW]) * RW'(dp_q) + RW'(den_q[DW-1:1]);
		end
	end

	assign trial = RW'(den_q) << bit_q;

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			tfcl_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_head.kind == tfcl_pkg::CMD_WRITE) begin
						ram_we = 1'b1;
					end else begin
						state_d = tfcl_pkg::ST_READ;
					end
				end
			end
			tfcl_pkg::ST_READ: begin
				state_d = (idx_q == cnt) ? tfcl_pkg::ST_EVAL : tfcl_pkg::ST_CMP;
			end
			tfcl_pkg::ST_CMP: begin
				state_d = hit ? tfcl_pkg::ST_EVAL : tfcl_pkg::ST_READ;
			end
			tfcl_pkg::ST_EVAL: begin
				if (cfg.interp_mode == tfcl_pkg::MODE_LINEAR && have_lo_q && have_hi_q) begin
					state_d = tfcl_pkg::ST_MUL;
				end else begin
					state_d = tfcl_pkg::ST_OUT;
				end
			end
			tfcl_pkg::ST_MUL: begin
				state_d = tfcl_pkg::ST_DIV;
			end
			tfcl_pkg::ST_DIV: begin
				if (bit_q == 3'd0) begin
					state_d = tfcl_pkg::ST_OUT;
				end
			end
			tfcl_pkg::ST_OUT: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = tfcl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tfcl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tfcl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tfcl_pkg::ST_IDLE: begin
				s_q       <= q_head.sample;
				idx_q     <= '0;
				have_lo_q <= 1'b0;
				have_hi_q <= 1'b0;
			end
			tfcl_pkg::ST_CMP: begin
				if (hit) begin
					have_hi_q <= 1'b1;
					n_q       <= rd_pos;
					cn_q      <= rd_color;
				end else begin
					have_lo_q <= 1'b1;
					p_q       <= rd_pos;
					cp_q      <= rd_color;
					idx_q     <= idx_q + CW'(1);
				end
			end
			tfcl_pkg::ST_EVAL: begin
				dp_q    <= dp_w;
				dn_q    <= dn_w;
				den_q   <= den_w;
				acc_q   <= pick;
				blend_q <= (cfg.interp_mode == tfcl_pkg::MODE_LINEAR) && have_lo_q && have_hi_q;
			end
			tfcl_pkg::ST_MUL: begin
				bit_q <= 3'd7;
				for (int k = 0; k < 4; k++) begin
					rem_q[k]  <= mul_sum[k];
					quot_q[k] <= '0;
				end
			end
			tfcl_pkg::ST_DIV: begin
				bit_q <= bit_q - 3'd1;
				for (int k = 0; k < 4; k++) begin
					if (rem_q[k] >= trial) begin
						rem_q[k]         <= rem_q[k] - trial;
						quot_q[k][bit_q] <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			res_q.out_red   <= res_word[KW-1:0];
			res_q.out_green <= res_word[2*KW-1:KW];
			res_q.out_blue  <= res_word[3*KW-1:2*KW];
			res_q.out_alpha <= res_word[4*KW-1:3*KW];
		end
	end

	assign res_word = blend_q ? {quot_q[3], quot_q[2], quot_q[1], quot_q[0]} : acc_q;

	assign result.valid   = out_valid_q;
	assign result.payload = res_q;

	assign stat.idle = (state_q == tfcl_pkg::ST_IDLE);
	assign stat.load = out_load;

endmodule

### src/transfer_function_color_lookup.sv
// top level of the piecewise linear rgba transfer function lookup
// usage:
//   item beats carry either a control point write (func low: slot, position,
//   rgba) or a lookup (func high: sample). a write yields no result beat, a
//   lookup yields exactly one result beat with the rgba color, in order.
//   points go in ascending position order; cfg_we/cfg_index/cfg_data set the
//   point count, linear or nearest mode and outside clamping. the user must
//   write them only while no beat is in flight; the block itself has no guard for this.
// sequence: a write goes into the table as it pops. a lookup pops, then
//   reads and compares each point visited through the registered ram read
//   port (one more read when no point lies above the sample), picks the
//   nearest/edge color and loads the result register. the blend adds a
//   multiply state and eight restoring divide steps (all four channels side
//   by side) before the load. the beat shows on the result channel the
//   cycle after the load and the next command pops then too.
// reset: registers return to count 2, linear mode, clamp on; table contents
//   are unknown until written. the two-entry queue keeps taking beats while
//   a result waits in the output register; when the receiver stalls the back
//   end stops before loading the next result and the queue then fills.
module transfer_function_color_lookup #(
	parameter int MAX_POINTS = tfcl_pkg::MAX_POINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tfcl_stream_if.sink                     item,
	tfcl_stream_if.source                   result,
	input  logic                            cfg_we,
	input  logic [tfcl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfcl_pkg::CFG_DATA_W-1:0] cfg_data
);

	tfcl_pkg::cfg_t     cfg_q;
	logic               q_valid;
	tfcl_pkg::cmd_t     q_head;
	logic               q_pop;
	tfcl_pkg::bk_stat_t stat;

	// configuration registers, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.point_count   <= tfcl_pkg::POINT_COUNT_RST;
			cfg_q.interp_mode   <= tfcl_pkg::INTERP_MODE_RST;
			cfg_q.clamp_outside <= tfcl_pkg::CLAMP_OUTSIDE_RST;
		end else if (cfg_we) begin
			case (tfcl_pkg::cfg_reg_t'(cfg_index))
				tfcl_pkg::CFG_POINT_COUNT: begin
					cfg_q.point_count <= cfg_data[tfcl_pkg::CNT_REG_W-1:0];
				end
				tfcl_pkg::CFG_INTERP_MODE: begin
					cfg_q.interp_mode <= cfg_data[0];
				end
				tfcl_pkg::CFG_CLAMP_OUTSIDE: begin
					cfg_q.clamp_outside <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// front: accept and queue
	tfcl_front #(
		.MAX_POINTS (MAX_POINTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	// back: table, scan, blend, result register
	tfcl_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.result  (result),
		.stat    (stat)
	);

	// a loaded result shows up on the result channel next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		stat.load |=> result.valid)
		else $error("loaded result not presented");

	// a new result beat only follows a load from the back end
	a_rise_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(stat.load))
		else $error("result valid rose without a load");

	// the front only backs up when the queue holds work for the back end
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> q_valid)
		else $error("front stalled with an empty queue");

	// the back end pops only from its idle state
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (stat.idle && q_valid))
		else $error("queue popped outside idle");

endmodule
